### hw/rtl/sea_pkg.sv
// Shared types and codes for the sector extent allocator.
// Used by sea_cell, the top level and the checker; no dependencies.
package sea_pkg;

   localparam logic [2:0] STATUS_GRANT   = 3'd0;
   localparam logic [2:0] STATUS_NOSPACE = 3'd1;
   localparam logic [2:0] STATUS_FREED   = 3'd2;
   localparam logic [2:0] STATUS_FULL    = 3'd3;
   localparam logic [2:0] STATUS_ZERO    = 3'd4;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_EVAL,
      OP_SHIFT,
      OP_TRIM,
      OP_JOIN_PREV,
      OP_JOIN_NEXT,
      OP_MERGE,
      OP_INSERT
   } cell_op_type;

   typedef struct packed {
      logic lt;
      logic overlap;
      logic join_prev;
      logic join_next;
   } cell_flag_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_FREE_EVAL,
      ST_FREE_APPLY,
      ST_REPLY
   } state_type;

endpackage

### hw/rtl/sea_cell.sv
// One slot of the free-extent chain: holds one extent and trades it with its neighbours.
// Depends on sea_pkg.
module sea_cell #(
   parameter int SW          = 16,
   parameter bit HEAD        = 1'b0,
   parameter int LAST_SECTOR = 65535
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sea_pkg::cell_op_type  op,
   input  logic [SW-1:0]         cmd_first,
   input  logic [SW-1:0]         cmd_last,
   input  logic                  left_valid,
   input  logic [SW-1:0]         left_start,
   input  logic [SW-1:0]         left_end,
   input  logic                  left_lt,
   input  logic                  right_valid,
   input  logic [SW-1:0]         right_start,
   input  logic [SW-1:0]         right_end,
   input  logic                  right_lt,
   output logic                  valid,
   output logic [SW-1:0]         start_sector,
   output logic [SW-1:0]         end_sector,
   output sea_pkg::cell_flag_type flags
);
   import sea_pkg::*;

   logic          valid_ff, valid_in;
   logic [SW-1:0] start_ff, start_in;
   logic [SW-1:0] end_ff, end_in;
   logic          lt_ff, lt_in;
   logic          prev_hit, next_hit;

   assign prev_hit = lt_ff && !right_lt;
   assign next_hit = valid_ff && !lt_ff && left_lt;

   always_comb begin
      flags.lt        = lt_ff;
      flags.overlap   = (prev_hit && end_ff >= cmd_first) ||
                        (next_hit && start_ff <= cmd_last);
      flags.join_prev = prev_hit && (({1'b0, end_ff} + 1'b1) == {1'b0, cmd_first});
      flags.join_next = next_hit && (({1'b0, cmd_last} + 1'b1) == {1'b0, start_ff});
   end

   always_comb begin
      valid_in = valid_ff;
      start_in = start_ff;
      end_in   = end_ff;
      lt_in    = lt_ff;
      unique case (op)
         OP_HOLD: begin
         end
         OP_EVAL: begin
            lt_in = valid_ff && (start_ff < cmd_first);
         end
         OP_SHIFT: begin
            valid_in = right_valid;
            start_in = right_start;
            end_in   = right_end;
         end
         OP_TRIM: begin
            if (HEAD) begin
               start_in = cmd_first;
            end
         end
         OP_JOIN_PREV: begin
            if (prev_hit) begin
               end_in = cmd_last;
            end
         end
         OP_JOIN_NEXT: begin
            if (next_hit) begin
               start_in = cmd_first;
            end
         end
         OP_MERGE: begin
            if (prev_hit) begin
               end_in = right_end;
            end else if (!lt_ff) begin
               valid_in = right_valid;
               start_in = right_start;
               end_in   = right_end;
            end
         end
         OP_INSERT: begin
            if (!lt_ff) begin
               if (left_lt) begin
                  valid_in = 1'b1;
                  start_in = cmd_first;
                  end_in   = cmd_last;
               end else begin
                  valid_in = left_valid;
                  start_in = left_start;
                  end_in   = left_end;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= HEAD;
         start_ff <= '0;
         end_ff   <= HEAD ? SW'(LAST_SECTOR) : '0;
         lt_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         start_ff <= start_in;
         end_ff   <= end_in;
         lt_ff    <= lt_in;
      end
   end

   assign valid        = valid_ff;
   assign start_sector = start_ff;
   assign end_sector   = end_ff;

endmodule

### hw/rtl/sector_extent_allocator_unit.sv
// First-fit sector allocator over a sorted, coalesced chain of free-extent cells.
// Depends on sea_pkg and sea_cell.
//
// One item is in work at a time. An allocation is accepted, then grants one extent per cycle
// while the result is not stalled (up to MAX_EXTENTS): the head cell of the chain is consumed
// and the chain shifts by one cell per grant; a zero or oversized request goes to the reply.
// A free is accepted, compares its position in every cell, inserts or merges, and replies.
// The chain resets to a single extent covering the whole disk.
module sector_extent_allocator_unit #(
   parameter int MAX_EXTENTS  = 16,
   parameter int DISK_SECTORS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [16:0] req_sector_count,
   input  logic [15:0] req_first_sector,
   input  logic [15:0] req_final_sector,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_extent_start,
   output logic [15:0] rsp_extent_end,
   output logic        rsp_last_of_run
);
   import sea_pkg::*;

   localparam int SW = $clog2(DISK_SECTORS);
   localparam int TW = $clog2(DISK_SECTORS + 1);
   localparam int CW = ((SW > 16) ? SW : 16) + 1;
   localparam int QW = (TW > 17) ? TW : 17;
   localparam int AW = ((SW + 1) > 17) ? (SW + 1) : 17;
   localparam logic [CW-1:0] DISK_C = CW'(DISK_SECTORS);

   state_type      state_ff, state_in;
   logic [16:0]    rem_ff, rem_in;
   logic [SW-1:0]  first_ff, first_in;
   logic [SW-1:0]  last_ff, last_in;
   logic [TW-1:0]  total_ff, total_in;
   logic [2:0]     reply_ff, reply_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;
   logic [15:0]    rsp_start_ff, rsp_start_in;
   logic [15:0]    rsp_end_ff, rsp_end_in;
   logic           rsp_last_ff, rsp_last_in;

   cell_op_type    op;
   logic [SW-1:0]  cmd_first;
   logic           v_w [MAX_EXTENTS];
   logic [SW-1:0]  s_w [MAX_EXTENTS];
   logic [SW-1:0]  e_w [MAX_EXTENTS];
   cell_flag_type  f_w [MAX_EXTENTS];
   logic           lv_w [MAX_EXTENTS];
   logic [SW-1:0]  ls_w [MAX_EXTENTS];
   logic [SW-1:0]  le_w [MAX_EXTENTS];
   logic           llt_w [MAX_EXTENTS];
   logic           rv_w [MAX_EXTENTS];
   logic [SW-1:0]  rs_w [MAX_EXTENTS];
   logic [SW-1:0]  re_w [MAX_EXTENTS];
   logic           rlt_w [MAX_EXTENTS];

   logic           any_overlap, any_join_prev, any_join_next;
   logic           req_accept, out_free, req_bad;
   logic [SW:0]    head_size;
   logic [CW-1:0]  head_start_c, head_end_c, part_end_c, trim_c;
   logic [SW:0]    free_size;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_EXTENTS; gi++) begin : g_cell
         if (gi == 0) begin : g_left_edge
            assign lv_w[gi]  = 1'b0;
            assign ls_w[gi]  = '0;
            assign le_w[gi]  = '0;
            assign llt_w[gi] = 1'b1;
         end else begin : g_left
            assign lv_w[gi]  = v_w[gi-1];
            assign ls_w[gi]  = s_w[gi-1];
            assign le_w[gi]  = e_w[gi-1];
            assign llt_w[gi] = f_w[gi-1].lt;
         end
         if (gi == MAX_EXTENTS - 1) begin : g_right_edge
            assign rv_w[gi]  = 1'b0;
            assign rs_w[gi]  = '0;
            assign re_w[gi]  = '0;
            assign rlt_w[gi] = 1'b0;
         end else begin : g_right
            assign rv_w[gi]  = v_w[gi+1];
            assign rs_w[gi]  = s_w[gi+1];
            assign re_w[gi]  = e_w[gi+1];
            assign rlt_w[gi] = f_w[gi+1].lt;
         end
         sea_cell #(
            .SW          (SW),
            .HEAD        (gi == 0),
            .LAST_SECTOR (DISK_SECTORS - 1)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .op          (op),
            .cmd_first   (cmd_first),
            .cmd_last    (last_ff),
            .left_valid  (lv_w[gi]),
            .left_start  (ls_w[gi]),
            .left_end    (le_w[gi]),
            .left_lt     (llt_w[gi]),
            .right_valid (rv_w[gi]),
            .right_start (rs_w[gi]),
            .right_end   (re_w[gi]),
            .right_lt    (rlt_w[gi]),
            .valid       (v_w[gi]),
            .start_sector(s_w[gi]),
            .end_sector  (e_w[gi]),
            .flags       (f_w[gi])
         );
      end
   endgenerate

   always_comb begin
      any_overlap   = 1'b0;
      any_join_prev = 1'b0;
      any_join_next = 1'b0;
      for (int i = 0; i < MAX_EXTENTS; i++) begin
         any_overlap   = any_overlap | f_w[i].overlap;
         any_join_prev = any_join_prev | f_w[i].join_prev;
         any_join_next = any_join_next | f_w[i].join_next;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_bad    = (req_final_sector < req_first_sector) ||
                       (CW'(req_final_sector) >= DISK_C);

   assign head_size    = {1'b0, e_w[0]} - {1'b0, s_w[0]} + 1'b1;
   assign head_start_c = CW'(s_w[0]);
   assign head_end_c   = CW'(e_w[0]);
   assign part_end_c   = head_start_c + CW'(rem_ff) - CW'(1);
   assign trim_c       = head_start_c + CW'(rem_ff);
   assign free_size    = {1'b0, last_ff} - {1'b0, first_ff} + 1'b1;
   assign cmd_first    = (state_ff == ST_ALLOC) ? SW'(trim_c) : first_ff;

   always_comb begin
      state_in      = state_ff;
      rem_in        = rem_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      total_in      = total_ff;
      reply_in      = reply_ff;
      op            = OP_HOLD;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rem_in   = req_sector_count;
               first_in = SW'(req_first_sector);
               last_in  = SW'(req_final_sector);
               if (!req_mode) begin
                  if (req_sector_count == 17'd0) begin
                     reply_in = STATUS_ZERO;
                     state_in = ST_REPLY;
                  end else if (QW'(req_sector_count) > QW'(total_ff)) begin
                     reply_in = STATUS_NOSPACE;
                     state_in = ST_REPLY;
                  end else begin
                     total_in = total_ff - TW'(req_sector_count);
                     state_in = ST_ALLOC;
                  end
               end else if (req_bad) begin
                  reply_in = STATUS_FULL;
                  state_in = ST_REPLY;
               end else begin
                  state_in = ST_FREE_EVAL;
               end
            end
         end
         ST_ALLOC: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_GRANT;
               rsp_start_in  = head_start_c[15:0];
               if (AW'(head_size) > AW'(rem_ff)) begin
                  rsp_end_in  = part_end_c[15:0];
                  rsp_last_in = 1'b1;
                  op          = OP_TRIM;
                  rem_in      = '0;
                  state_in    = ST_IDLE;
               end else begin
                  rsp_end_in  = head_end_c[15:0];
                  rsp_last_in = (AW'(head_size) == AW'(rem_ff));
                  op          = OP_SHIFT;
                  rem_in      = rem_ff - 17'(head_size);
                  if (AW'(head_size) == AW'(rem_ff)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_FREE_EVAL: begin
            op       = OP_EVAL;
            state_in = ST_FREE_APPLY;
         end
         ST_FREE_APPLY: begin
            state_in = ST_REPLY;
            priority if (any_overlap) begin
               reply_in = STATUS_FULL;
            end else if (any_join_prev && any_join_next) begin
               op       = OP_MERGE;
               reply_in = STATUS_FREED;
               total_in = total_ff + TW'(free_size);
            end else if (any_join_prev) begin
               op       = OP_JOIN_PREV;
               reply_in = STATUS_FREED;
               total_in = total_ff + TW'(free_size);
            end else if (any_join_next) begin
               op       = OP_JOIN_NEXT;
               reply_in = STATUS_FREED;
               total_in = total_ff + TW'(free_size);
            end else if (v_w[MAX_EXTENTS-1]) begin
               reply_in = STATUS_FULL;
            end else begin
               op       = OP_INSERT;
               reply_in = STATUS_FREED;
               total_in = total_ff + TW'(free_size);
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = reply_ff;
               rsp_start_in  = '0;
               rsp_end_in    = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= TW'(DISK_SECTORS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      reply_ff      <= reply_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_extent_start = rsp_start_ff;
   assign rsp_extent_end   = rsp_end_ff;
   assign rsp_last_of_run  = rsp_last_ff;

endmodule

### hw/rtl/sea_checker.sv
// Port-level checks for sector_extent_allocator_unit, attached by bind.
// Depends on sea_pkg.
module sea_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_extent_start,
   input logic [15:0] rsp_extent_end,
   input logic        rsp_last_of_run
);
   import sea_pkg::*;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while a transfer is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_extent_start) && $stable(rsp_extent_end))
      else $error("stalled transfer changed");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_GRANT |-> rsp_last_of_run)
      else $error("status result not marked last");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_GRANT |->
         rsp_extent_start == 16'd0 && rsp_extent_end == 16'd0)
      else $error("status result carries an extent");

endmodule

bind sector_extent_allocator_unit sea_checker u_sea_checker (.*);
